FILE: hdl/addressable_led_spi_frame_encoder_assert.svh
// Assertion macros for the LED frame encoder.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef ADDRESSABLE_LED_SPI_FRAME_ENCODER_ASSERT_SVH
`define ADDRESSABLE_LED_SPI_FRAME_ENCODER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define ALSFE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("alsfe assertion failed");

// Next-cycle implication, checked outside reset
`define ALSFE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("alsfe assertion failed");

`endif

FILE: hdl/alsfe_pkg.sv
// Shared types, constants and encoding functions for the LED frame encoder.
// No dependencies.
package alsfe_pkg;

    // String length and derived widths
    localparam int LED_COUNT = 72;
    localparam int LED_IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam logic [LED_IDX_W:0]   LED_COUNT_V = (LED_IDX_W + 1)'(LED_COUNT);
    localparam logic [LED_IDX_W-1:0] LED_LAST    = LED_IDX_W'(LED_COUNT - 1);

    // Field widths
    localparam int CMD_W   = 2;
    localparam int POS_W   = 16;
    localparam int COLOR_W = 24;
    localparam int WORD_W  = 16;
    localparam int LATCH_W = 12;
    localparam int WCUR_W  = 3;

    localparam logic [LATCH_W-1:0] LATCH_RESET = LATCH_W'(3024);
    localparam logic [WCUR_W-1:0]  LAST_WORD   = WCUR_W'(5);

    // Position reduction: quotient by reciprocal multiply, exact for 16-bit positions
    localparam int MOD_SHIFT    = POS_W + $clog2(LED_COUNT);
    localparam int MOD_MULT_W   = POS_W + 1;
    localparam int MOD_PROD_W   = 48;
    localparam int MOD_MULT_INT = ((1 << MOD_SHIFT) + LED_COUNT - 1) / LED_COUNT;
    localparam logic [MOD_MULT_W-1:0] MOD_MULT = MOD_MULT_W'(MOD_MULT_INT);

    // Commands
    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_FILL  = 2'd1,
        CMD_REQ   = 2'd2
    } t_cmd;

    // Request bundle toward the color store
    typedef struct packed {
        logic                 wr_en;
        logic                 fill_en;
        logic                 rd_en;
        logic [LED_IDX_W-1:0] wr_addr;
        logic [LED_IDX_W-1:0] rd_addr;
        logic [COLOR_W-1:0]   color;
    } t_store_req;

    // Pick the nibble sent in a given word of an LED: G, R, B, high nibble first
    function automatic logic [3:0] nibble_of(input logic [COLOR_W-1:0] color,
                                             input logic [WCUR_W-1:0]  wsel);
        logic [3:0] nib;
        case (wsel)
            3'd0:    nib = color[15:12];
            3'd1:    nib = color[11:8];
            3'd2:    nib = color[23:20];
            3'd3:    nib = color[19:16];
            3'd4:    nib = color[7:4];
            default: nib = color[3:0];
        endcase
        return nib;
    endfunction

    // Each bit b becomes the line symbol 1,b,0,0, first bit on top
    function automatic logic [WORD_W-1:0] encode_nibble(input logic [3:0] nib);
        logic [WORD_W-1:0] word;
        for (int k = 0; k < 4; k++) begin
            word[WORD_W-1-4*k -: 4] = {1'b1, nib[3-k], 2'b00};
        end
        return word;
    endfunction

endpackage

FILE: hdl/alsfe_color_store.sv
// Color store: one synchronous RAM word per LED plus per-entry written bits
// and a fill color, so a fill clears only the written bits. Uses alsfe_pkg.
module alsfe_color_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  alsfe_pkg::t_store_req         i_req,
    output logic [alsfe_pkg::COLOR_W-1:0] o_rd_color
);

    logic [alsfe_pkg::COLOR_W-1:0] mem [alsfe_pkg::LED_COUNT];
    logic [alsfe_pkg::LED_COUNT-1:0] r_written;
    logic [alsfe_pkg::COLOR_W-1:0]   r_fill_color;
    logic [alsfe_pkg::COLOR_W-1:0]   r_rd_data;
    logic                            r_rd_hit;

    // RAM write and registered read
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.color;
        end
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_addr];
        end
    end

    // Written bits and fill color; an unwritten entry reads as the fill color
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_fill_color <= '0;
            r_rd_hit     <= 1'b0;
        end else begin
            if (i_req.fill_en) begin
                r_written    <= '0;
                r_fill_color <= i_req.color;
            end else if (i_req.wr_en) begin
                r_written[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_hit <= r_written[i_req.rd_addr];
            end
        end
    end

    assign o_rd_color = r_rd_hit ? r_rd_data : r_fill_color;

endmodule

FILE: hdl/addressable_led_spi_frame_encoder.sv
// Top level of the addressable LED frame encoder: command FSM, cursors, output word.
// Depends on alsfe_pkg, alsfe_color_store and addressable_led_spi_frame_encoder_assert.svh.
//
//  channel   handshake           payload
//  -------   -----------------   ---------------------------------
//  input     i_valid / o_stall   i_command, i_position, i_color
//  output    o_valid / i_stall   o_spi_word, o_frame_last
//  config    i_cfg_we            i_cfg_data (latch_words)
//
// Fill completes on accept; write does the quotient multiply on accept, then the
// remainder and RAM write in S_WR. Word request: RAM read on accept, then encode into
// the output register in S_RESP, which holds while a previous word sits unread there.
// One command is in flight at a time; o_stall is high while it is being worked.
// Synchronous active-low reset clears cursors, store to dark, latch_words to 3024.
`include "addressable_led_spi_frame_encoder_assert.svh"

module addressable_led_spi_frame_encoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [alsfe_pkg::CMD_W-1:0]   i_command,
    input  logic [alsfe_pkg::POS_W-1:0]   i_position,
    input  logic [alsfe_pkg::COLOR_W-1:0] i_color,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [alsfe_pkg::WORD_W-1:0]  o_spi_word,
    output logic                          o_frame_last,
    input  logic                          i_cfg_we,
    input  logic [alsfe_pkg::LATCH_W-1:0] i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WR,
        S_RESP
    } t_state;

    t_state                          r_state;
    logic [alsfe_pkg::LATCH_W-1:0]   r_latch_words;
    logic [alsfe_pkg::LED_IDX_W-1:0] r_led_cursor;
    logic [alsfe_pkg::WCUR_W-1:0]    r_word_cursor;
    logic [alsfe_pkg::LATCH_W-1:0]   r_latch_count;
    logic                            r_in_latch;
    logic                            r_o_valid;
    logic [alsfe_pkg::WORD_W-1:0]    r_spi_word;
    logic                            r_frame_last;
    logic [alsfe_pkg::POS_W-1:0]     r_pos;
    logic [alsfe_pkg::POS_W-1:0]     r_quot;
    logic [alsfe_pkg::COLOR_W-1:0]   r_color;

    logic                            w_accept;
    logic                            w_slot_free;
    alsfe_pkg::t_cmd                 w_cmd;
    logic [alsfe_pkg::MOD_PROD_W-1:0] w_prod;
    logic [alsfe_pkg::POS_W-1:0]     w_qn;
    logic [alsfe_pkg::POS_W-1:0]     w_rem;
    logic [alsfe_pkg::LATCH_W:0]     n_latch_count;
    logic [alsfe_pkg::COLOR_W-1:0]   w_rd_color;
    alsfe_pkg::t_store_req           w_req;

    assign w_accept    = i_valid && (r_state == S_IDLE);
    assign w_slot_free = !r_o_valid || !i_stall;
    assign w_cmd       = alsfe_pkg::t_cmd'(i_command);

    // Position modulo LED count: quotient on accept, remainder in S_WR
    assign w_prod = alsfe_pkg::MOD_PROD_W'(i_position)
                  * alsfe_pkg::MOD_PROD_W'(alsfe_pkg::MOD_MULT);
    assign w_qn   = r_quot * alsfe_pkg::POS_W'(alsfe_pkg::LED_COUNT);
    assign w_rem  = r_pos - w_qn;

    assign n_latch_count = {1'b0, r_latch_count} + 1'b1;

    // Store requests
    always_comb begin
        w_req         = '0;
        w_req.rd_addr = r_led_cursor;
        w_req.wr_addr = w_rem[alsfe_pkg::LED_IDX_W-1:0];
        w_req.color   = (r_state == S_WR) ? r_color : i_color;
        w_req.wr_en   = (r_state == S_WR);
        w_req.fill_en = w_accept && (w_cmd == alsfe_pkg::CMD_FILL);
        w_req.rd_en   = w_accept && (w_cmd == alsfe_pkg::CMD_REQ);
    end

    alsfe_color_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .o_rd_color (w_rd_color)
    );

    // Payload captured on accept
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pos   <= i_position;
            r_quot  <= alsfe_pkg::POS_W'(w_prod >> alsfe_pkg::MOD_SHIFT);
            r_color <= i_color;
        end
    end

    // Command FSM, frame cursors and output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_latch_words <= alsfe_pkg::LATCH_RESET;
            r_led_cursor  <= '0;
            r_word_cursor <= '0;
            r_latch_count <= '0;
            r_in_latch    <= 1'b0;
            r_o_valid     <= 1'b0;
            r_spi_word    <= '0;
            r_frame_last  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_latch_words <= i_cfg_data;
            end
            // output word valid: set when a word is produced, cleared when taken
            if ((r_state == S_RESP) && w_slot_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        unique case (w_cmd)
                            alsfe_pkg::CMD_WRITE: r_state <= S_WR;
                            alsfe_pkg::CMD_REQ:   r_state <= S_RESP;
                            default:              r_state <= S_IDLE;
                        endcase
                    end
                end
                S_WR: begin
                    r_state <= S_IDLE;
                end
                S_RESP: begin
                    if (w_slot_free) begin
                        r_state   <= S_IDLE;
                        if (r_in_latch) begin
                            // latch gap: zero words, last one flagged
                            r_spi_word <= '0;
                            if (n_latch_count >= {1'b0, r_latch_words}) begin
                                r_frame_last  <= 1'b1;
                                r_in_latch    <= 1'b0;
                                r_latch_count <= '0;
                            end else begin
                                r_frame_last  <= 1'b0;
                                r_latch_count <= n_latch_count[alsfe_pkg::LATCH_W-1:0];
                            end
                        end else begin
                            r_spi_word   <= alsfe_pkg::encode_nibble(
                                alsfe_pkg::nibble_of(w_rd_color, r_word_cursor));
                            r_frame_last <= 1'b0;
                            if (r_word_cursor == alsfe_pkg::LAST_WORD) begin
                                r_word_cursor <= '0;
                                if (r_led_cursor == alsfe_pkg::LED_LAST) begin
                                    r_led_cursor  <= '0;
                                    r_latch_count <= '0;
                                    r_in_latch    <= (r_latch_words != '0);
                                end else begin
                                    r_led_cursor <= r_led_cursor + 1'b1;
                                end
                            end else begin
                                r_word_cursor <= r_word_cursor + 1'b1;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_o_valid;
    assign o_spi_word   = r_spi_word;
    assign o_frame_last = r_frame_last;

    // Checks
    `ALSFE_ASSERT_NOW(a_last_is_zero, o_valid && o_frame_last, o_spi_word == '0)
    `ALSFE_ASSERT_NOW(a_word_symbols, o_valid,
        ((o_spi_word & 16'h3333) == '0) &&
        (((o_spi_word & 16'h8888) == 16'h8888) || (o_spi_word == '0)))
    `ALSFE_ASSERT_NOW(a_cursor_range, 1'b1,
        ({1'b0, r_led_cursor} < alsfe_pkg::LED_COUNT_V) &&
        (r_word_cursor <= alsfe_pkg::LAST_WORD))
    `ALSFE_ASSERT_NOW(a_rem_range, r_state == S_WR,
        w_rem < alsfe_pkg::POS_W'(alsfe_pkg::LED_COUNT))
    `ALSFE_ASSERT_NEXT(a_req_to_resp, w_accept && (w_cmd == alsfe_pkg::CMD_REQ),
        r_state == S_RESP)

endmodule
